// ===== src/ow_bsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ow_bsm_pkg
// Shared types and constants for the one-wire bit-slot master.
// ----------------------------------------------------------------------------
package ow_bsm_pkg;

   // Command and tick codes carried in the request tuser
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_TOUCH = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   // Register map
   localparam int CFG_COUNT   = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_WZ_LOW      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WZ_RECOVERY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RD_LOW      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RD_RELEASE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RD_RECOVERY = 3'd4;

   // Reset values of the timing registers, in ticks
   localparam logic [CSR_DATA_W-1:0] RST_WZ_LOW      = 10'd60;
   localparam logic [CSR_DATA_W-1:0] RST_WZ_RECOVERY = 10'd10;
   localparam logic [CSR_DATA_W-1:0] RST_RD_LOW      = 10'd6;
   localparam logic [CSR_DATA_W-1:0] RST_RD_RELEASE  = 10'd9;
   localparam logic [CSR_DATA_W-1:0] RST_RD_RECOVERY = 10'd55;

   // Byte framing
   localparam int                BITS_PER_BYTE = 8;
   localparam int                COUNT_W       = 3;
   localparam logic [COUNT_W-1:0] LAST_BIT     = 3'(BITS_PER_BYTE - 1);
   localparam logic [BITS_PER_BYTE-1:0] READ_FILL = 8'hFF;

   // Stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // One result word
   typedef struct packed {
      logic                     rejected;
      logic [BITS_PER_BYTE-1:0] read_value;
      logic                     done_res;
      logic                     busy_res;
      logic                     pull_low;
   } rsp_word_type;

endpackage

// ===== src/ow_bsm_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ow_bsm_csr
// Timing register file; values are kept masked to the phase timer width.
// ----------------------------------------------------------------------------
module ow_bsm_csr #(
   parameter int TIMER_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_fire,
   input  logic [ow_bsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ow_bsm_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic [ow_bsm_pkg::CFG_COUNT-1:0][TIMER_BITS-1:0] lengths
);
   import ow_bsm_pkg::*;

   localparam int KEEP_W = (TIMER_BITS < CSR_DATA_W) ? TIMER_BITS : CSR_DATA_W;

   logic [CFG_COUNT-1:0][TIMER_BITS-1:0] cfg_ff;

   function automatic logic [TIMER_BITS-1:0] trim(input logic [CSR_DATA_W-1:0] v);
      return TIMER_BITS'(v[KEEP_W-1:0]);
   endfunction

   // Register writes; indexes past the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0] <= trim(RST_WZ_LOW);
         cfg_ff[1] <= trim(RST_WZ_RECOVERY);
         cfg_ff[2] <= trim(RST_RD_LOW);
         cfg_ff[3] <= trim(RST_RD_RELEASE);
         cfg_ff[4] <= trim(RST_RD_RECOVERY);
      end else if (csr_fire) begin
         case (csr_index)
            REG_WZ_LOW:      cfg_ff[0] <= trim(csr_data);
            REG_WZ_RECOVERY: cfg_ff[1] <= trim(csr_data);
            REG_RD_LOW:      cfg_ff[2] <= trim(csr_data);
            REG_RD_RELEASE:  cfg_ff[3] <= trim(csr_data);
            REG_RD_RECOVERY: cfg_ff[4] <= trim(csr_data);
            default: ;
         endcase
      end
   end

   assign lengths = cfg_ff;

endmodule

// ===== src/ow_bsm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ow_bsm_engine
// Slot sequencer: phase, timer, bit count and shift register, advanced once
// per accepted word. A tick may close up to three phases in one step.
// ----------------------------------------------------------------------------
module ow_bsm_engine #(
   parameter int TIMER_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_fire,
   input  ow_bsm_pkg::action_type                action,
   input  logic [ow_bsm_pkg::BITS_PER_BYTE-1:0]  command_data,
   input  logic                                  line_level,
   input  logic [ow_bsm_pkg::CFG_COUNT-1:0][TIMER_BITS-1:0] lengths,
   output ow_bsm_pkg::rsp_word_type              result
);
   import ow_bsm_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_LOW      = 2'd1,
      PH_RELEASE  = 2'd2,
      PH_RECOVERY = 2'd3
   } phase_type;

   localparam int PHASE_STEPS = 3;

   phase_type                phase_ff,   phase_in;
   logic [TIMER_BITS-1:0]    timer_ff,   timer_in;
   logic [COUNT_W-1:0]       count_ff,   count_in;
   logic [BITS_PER_BYTE-1:0] shift_ff,   shift_in;
   action_type               kind_ff,    kind_in;
   logic                     sampled_ff, sampled_in;

   logic [TIMER_BITS-1:0] wz_low, wz_rec, rd_low, rd_rel, rd_rec;

   assign wz_low = lengths[0];
   assign wz_rec = lengths[1];
   assign rd_low = lengths[2];
   assign rd_rel = lengths[3];
   assign rd_rec = lengths[4];

   // Low time of a new slot; a zero setting still gives one tick
   function automatic logic [TIMER_BITS-1:0] low_len(
      input logic                  read_slot,
      input logic [TIMER_BITS-1:0] rd,
      input logic [TIMER_BITS-1:0] wz
   );
      logic [TIMER_BITS-1:0] t;
      t = read_slot ? rd : wz;
      if (t == '0) t = TIMER_BITS'(1);
      return t;
   endfunction

   // Next state and result of one word
   always_comb begin
      logic done_v;
      logic rej_v;
      logic last_v;
      logic [BITS_PER_BYTE-1:0] value_v;

      phase_in   = phase_ff;
      timer_in   = timer_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      kind_in    = kind_ff;
      sampled_in = sampled_ff;
      done_v     = 1'b0;
      rej_v      = 1'b0;
      last_v     = 1'b0;
      value_v    = '0;

      if (action == ACT_TICK) begin
         if (phase_ff != PH_IDLE) begin
            timer_in = timer_ff - TIMER_BITS'(1);
            // expired phases chain on the same tick
            for (int i = 0; i < PHASE_STEPS; i++) begin
               if (timer_in == '0 && phase_in != PH_IDLE) begin
                  case (phase_in)
                     PH_LOW: begin
                        if (shift_in[0]) begin
                           phase_in = PH_RELEASE;
                           timer_in = rd_rel;
                        end else begin
                           sampled_in = 1'b0;
                           phase_in   = PH_RECOVERY;
                           timer_in   = wz_rec;
                        end
                     end
                     PH_RELEASE: begin
                        sampled_in = line_level;
                        phase_in   = PH_RECOVERY;
                        timer_in   = rd_rec;
                     end
                     PH_RECOVERY: begin
                        last_v   = (kind_in == ACT_TOUCH) || (count_in == LAST_BIT);
                        shift_in = {sampled_in, shift_in[BITS_PER_BYTE-1:1]};
                        count_in = count_in + COUNT_W'(1);
                        if (last_v) begin
                           phase_in = PH_IDLE;
                           timer_in = '0;
                           count_in = '0;
                           done_v   = 1'b1;
                        end else begin
                           phase_in = PH_LOW;
                           timer_in = low_len(shift_in[0], rd_low, wz_low);
                        end
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
            if (done_v) begin
               if (kind_in == ACT_TOUCH)
                  value_v = BITS_PER_BYTE'(sampled_in);
               else if (kind_in == ACT_READ)
                  value_v = shift_in;
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         rej_v = 1'b1;
      end else begin
         // new command: first slot starts driving low at once
         kind_in    = action;
         count_in   = '0;
         sampled_in = 1'b0;
         if (action == ACT_TOUCH)
            shift_in = BITS_PER_BYTE'(command_data[0]);
         else if (action == ACT_WRITE)
            shift_in = command_data;
         else
            shift_in = READ_FILL;
         phase_in = PH_LOW;
         timer_in = low_len(shift_in[0], rd_low, wz_low);
      end

      result.pull_low   = (phase_in == PH_LOW);
      result.busy_res   = (phase_in != PH_IDLE);
      result.done_res   = done_v;
      result.read_value = value_v;
      result.rejected   = rej_v;
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         timer_ff   <= '0;
         count_ff   <= '0;
         shift_ff   <= '0;
         kind_ff    <= ACT_TICK;
         sampled_ff <= 1'b0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         count_ff   <= count_in;
         shift_ff   <= shift_in;
         kind_ff    <= kind_in;
         sampled_ff <= sampled_in;
      end
   end

endmodule

// ===== src/one_wire_bit_slot_master_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bit_slot_master_unit
// One-wire bus master that times write-zero and read slots from tick words.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per tick (1 us, with the sampled line level) or per
//            command (touch bit, write byte, read byte). tuser is the action.
//   rsp_*  : exactly one result word per request word: pull-low drive, busy,
//            done, read value and a rejected flag for commands sent while busy.
//   csr_*  : timing register writes, taken every cycle; write only while idle.
// The result of a request word is written to the output register on the edge
// that accepts it. Throughput is one word per cycle while the receiver takes
// results, set by the single-step sequencer update; a tick may close up to three
// slot phases in that step.
// When the receiver stalls, the result holds and a new request is taken only
// in the cycle the held result is taken, so req_tready follows rsp_tready.
// Reset (synchronous) returns the sequencer to idle, empties the output
// register and loads the default slot timings.
// ----------------------------------------------------------------------------
module one_wire_bit_slot_master_unit #(
   parameter int TIMER_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [ow_bsm_pkg::REQ_DATA_W-1:0]      req_tdata,  // command_data[7:0], line_level[8]
   input  logic [1:0]                             req_tuser,  // action[1:0]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [ow_bsm_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // pull_low[0], busy_res[1],
                                                              // done_res[2], read_value[10:3],
                                                              // rejected[11]
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ow_bsm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ow_bsm_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ow_bsm_pkg::*;

   logic                                 req_fire;
   logic                                 csr_fire;
   logic [CFG_COUNT-1:0][TIMER_BITS-1:0] lengths;
   rsp_word_type                         result;
   logic                                 rsp_valid_ff;
   rsp_word_type                         rsp_word_ff;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   ow_bsm_csr #(.TIMER_BITS(TIMER_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_fire),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .lengths   (lengths)
   );

   ow_bsm_engine #(.TIMER_BITS(TIMER_BITS)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .action       (action_type'(req_tuser)),
      .command_data (req_tdata[BITS_PER_BYTE-1:0]),
      .line_level   (req_tdata[BITS_PER_BYTE]),
      .lengths      (lengths),
      .result       (result)
   );

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (req_fire)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (req_fire) rsp_word_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_word_ff);

endmodule

// ===== src/ow_bsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ow_bsm_checker
// Port-level checks on the result stream of the bit-slot master.
// ----------------------------------------------------------------------------
module ow_bsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Reset empties the output register
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A completed command leaves the bus idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1] && !rsp_tdata[0])
      else $error("done reported while still busy");

   // Rejection only while a slot runs, never together with done
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> rsp_tdata[1] && !rsp_tdata[2])
      else $error("reject without a running slot");

   // Read value is zero unless done, and line pulled low only while busy
   a_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[10:3] == 8'd0
                                     && (!rsp_tdata[0] || rsp_tdata[1]))
      else $error("read value or drive outside a command");

endmodule

bind one_wire_bit_slot_master_unit ow_bsm_checker u_ow_bsm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the one-wire bit-slot master. A scoreboard class
// keeps its own copy of the slot sequencer and timing registers. Each request
// word is predicted when it is taken, and every response word is compared
// field by field. The run covers reset timings, a short directed pass with
// zero timings, a long slot with the top timer bit set, and random command
// sequences under several timing sets and idle/stall mixes. Random noise
// words are mixed in.
// ----------------------------------------------------------------------------
module testbench;
   import ow_bsm_pkg::*;

   localparam int TIMER_BITS     = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 200;
   localparam int END_WAIT       = 4;
   localparam int RANDOM_TARGET  = 64;
   localparam int RANDOM_PHASES  = 8;
   localparam int REPORT_LIMIT   = 100;
   localparam int REJECT_PCT     = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam logic [CSR_DATA_W-1:0]  TIME_LONG  = 10'h200;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_LOW      = 2'd1,
      PH_RELEASE  = 2'd2,
      PH_RECOVERY = 2'd3
   } slot_phase_type;

   // Slot sequencer shadow and queue of expected response words
   class slot_timing_scoreboard;
      logic [CSR_DATA_W-1:0] timing [CFG_COUNT];
      slot_phase_type        phase;
      logic [TIMER_BITS-1:0] timer;
      logic [COUNT_W-1:0]    bit_count;
      logic [7:0]            shift;
      action_type            kind;
      logic                  sampled;
      rsp_word_type          expected_q [$];
      int                    errors;
      int                    done_count;
      int                    reject_count;

      function new();
         timing[REG_WZ_LOW]      = RST_WZ_LOW;
         timing[REG_WZ_RECOVERY] = RST_WZ_RECOVERY;
         timing[REG_RD_LOW]      = RST_RD_LOW;
         timing[REG_RD_RELEASE]  = RST_RD_RELEASE;
         timing[REG_RD_RECOVERY] = RST_RD_RECOVERY;
         phase     = PH_IDLE;
         timer     = '0;
         bit_count = '0;
         shift     = '0;
         kind      = ACT_TICK;
         sampled   = 1'b0;
      endfunction

      // Indexes past the register map are dropped
      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         if (index < CFG_COUNT) timing[index] = value;
      endfunction

      function bit busy();
         return phase != PH_IDLE;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Start a slot chosen by the next data bit; low time zero runs as one
      function void begin_slot();
         logic [TIMER_BITS-1:0] t;
         t = shift[0] ? timing[REG_RD_LOW] : timing[REG_WZ_LOW];
         if (t == 0) t = 1;
         phase = PH_LOW;
         timer = t;
      endfunction

      // Close every phase whose timer has expired; 1 when the command ends
      function bit close_phases(logic level);
         bit last;
         while (timer == 0 && phase != PH_IDLE) begin
            case (phase)
               PH_LOW: begin
                  if (shift[0]) begin
                     phase = PH_RELEASE;
                     timer = timing[REG_RD_RELEASE];
                  end else begin
                     sampled = 1'b0;
                     phase   = PH_RECOVERY;
                     timer   = timing[REG_WZ_RECOVERY];
                  end
               end
               PH_RELEASE: begin
                  sampled = level;
                  phase   = PH_RECOVERY;
                  timer   = timing[REG_RD_RECOVERY];
               end
               default: begin
                  last      = (kind == ACT_TOUCH) || (bit_count >= LAST_BIT);
                  shift     = {sampled, shift[7:1]};
                  bit_count = bit_count + 1'b1;
                  if (last) begin
                     phase     = PH_IDLE;
                     timer     = '0;
                     bit_count = '0;
                     return 1'b1;
                  end
                  begin_slot();
               end
            endcase
         end
         return 1'b0;
      endfunction

      // Predict the response to one accepted request word
      function void note_request(action_type act, logic [7:0] data, logic level);
         rsp_word_type w;
         w = '0;
         if (act == ACT_TICK) begin
            if (phase != PH_IDLE) begin
               timer = timer - 1'b1;
               if (close_phases(level)) begin
                  w.done_res = 1'b1;
                  done_count++;
                  if (kind == ACT_TOUCH) w.read_value = {7'd0, sampled};
                  else if (kind == ACT_READ) w.read_value = shift;
               end
            end
         end else if (phase != PH_IDLE) begin
            w.rejected = 1'b1;
            reject_count++;
         end else begin
            kind      = act;
            bit_count = '0;
            sampled   = 1'b0;
            case (act)
               ACT_TOUCH: shift = {7'd0, data[0]};
               ACT_WRITE: shift = data;
               default:   shift = READ_FILL;
            endcase
            begin_slot();
         end
         w.pull_low = (phase == PH_LOW);
         w.busy_res = (phase != PH_IDLE);
         expected_q.push_back(w);
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0d, actual %0d",
                        $time, field, want, got);
         end
      endfunction

      // Compare a taken response word with the oldest prediction
      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response word with nothing expected, expected none, actual %h",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         compare_field("pull_low",   want.pull_low,   got.pull_low);
         compare_field("busy_res",   want.busy_res,   got.busy_res);
         compare_field("done_res",   want.done_res,   got.done_res);
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("rejected",   want.rejected,   got.rejected);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;   // command_data[7:0], line_level[8]
   logic [1:0]             req_tuser = ACT_TICK;  // action[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;       // pull_low[0], busy_res[1], done_res[2],
                                            // read_value[10:3], rejected[11]
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   slot_timing_scoreboard sb = new();

   int tx_idle_pct   = 0;
   int rx_stall_pct  = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int words_counted = 0;
   int csr_writes    = 0;
   int quiet_cycles  = 0;
   int tx_idle_mode [4] = '{0, 57, 0, 25};
   int rx_stall_mode [4] = '{0, 0, 57, 25};

   one_wire_bit_slot_master_unit #(.TIMER_BITS(TIMER_BITS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check taken words, then pick next ready (long hold-off on request)
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         sb.check_result(rsp_word_type'(rsp_tdata[$bits(rsp_word_type)-1:0]));
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request word after a random gap; predict it when taken
   task automatic send_word(action_type act, logic [7:0] data, logic level);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, level, data};
      do @(posedge clock); while (!req_tready);
      if (act != ACT_TICK || sb.busy()) words_counted++;
      sb.note_request(act, data, level);
   endtask

   task automatic send_tick();
      send_word(ACT_TICK, 8'($urandom), 1'($urandom));
   endtask

   // Stop offering and wait for every predicted response
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, value);
      csr_writes++;
   endtask

   // Load all slot timings once the block is idle
   task automatic program_timing(logic [CSR_DATA_W-1:0] wz_low, logic [CSR_DATA_W-1:0] wz_rec,
                                 logic [CSR_DATA_W-1:0] rd_low, logic [CSR_DATA_W-1:0] rd_rel,
                                 logic [CSR_DATA_W-1:0] rd_rec);
      drain();
      write_csr(REG_WZ_LOW, wz_low);
      write_csr(REG_WZ_RECOVERY, wz_rec);
      write_csr(REG_RD_LOW, rd_low);
      write_csr(REG_RD_RELEASE, rd_rel);
      write_csr(REG_RD_RECOVERY, rd_rec);
      write_csr(REG_UNUSED, 10'($urandom));
      csr_valid <= 1'b0;
   endtask

   // One command followed by ticks until it completes, with stray commands
   task automatic run_command(action_type act, logic [7:0] data);
      while (sb.busy()) send_tick();
      send_word(act, data, 1'($urandom));
      while (sb.busy()) begin
         if ($urandom_range(99) < REJECT_PCT)
            send_word(action_type'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
         else
            send_tick();
      end
   endtask

   // Mostly complete command sequences, some raw noise words
   task automatic random_traffic(int target);
      int start_count;
      int n;
      start_count = words_counted;
      while (words_counted - start_count < target) begin
         if ($urandom_range(99) < 85) begin
            run_command(action_type'($urandom_range(1, 3)), 8'($urandom));
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_word(action_type'($urandom_range(0, 3)), 8'($urandom),
                                 1'($urandom));
         end
      end
      while (sb.busy()) send_tick();
   endtask

   initial begin
      logic [7:0] levels;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset timings: one write-zero slot and one read slot
      run_command(ACT_TOUCH, 8'h00);
      run_command(ACT_TOUCH, 8'h01);

      // Directed pass with all timings zero: one tick per slot
      program_timing('0, '0, '0, '0, '0);
      send_word(ACT_TICK, 8'hFF, 1'b1);     // tick while idle
      send_word(ACT_TOUCH, 8'hFE, 1'b1);    // write-zero, level ignored
      send_word(ACT_TICK, 8'h00, 1'b1);
      send_word(ACT_TOUCH, 8'h01, 1'b0);    // read slot sees high
      send_word(ACT_TICK, 8'h00, 1'b1);
      send_word(ACT_TOUCH, 8'hFF, 1'b1);    // read slot sees low
      send_word(ACT_TICK, 8'h00, 1'b0);
      send_word(ACT_WRITE, 8'hFF, 1'b0);
      send_word(ACT_WRITE, 8'h00, 1'b1);    // busy: rejected
      send_word(ACT_TOUCH, 8'h01, 1'b0);    // busy: rejected
      repeat (8) send_word(ACT_TICK, 8'h00, 1'b1);
      send_word(ACT_READ, 8'h00, 1'b0);
      send_word(ACT_READ, 8'hFF, 1'b1);     // busy: rejected
      levels = 8'hB2;
      for (int i = 0; i < 8; i++) send_word(ACT_TICK, 8'hFF, levels[i]);

      // Long write-zero slot with the top timer bit set
      program_timing(TIME_LONG, '0, '0, '0, '0);
      run_command(ACT_TOUCH, 8'h00);

      // Random phases over timing sets and idle/stall mixes
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         tx_idle_pct  = tx_idle_mode[p % 4];
         rx_stall_pct = rx_stall_mode[p % 4];
         if (p == 3)
            program_timing('0, '0, '0, '0, '0);
         else
            program_timing(10'($urandom_range(0, 5)), 10'($urandom_range(0, 5)),
                           10'($urandom_range(0, 5)), 10'($urandom_range(0, 5)),
                           10'($urandom_range(0, 5)));
         random_traffic(RANDOM_TARGET / 2);
         if (p == 1) hold_requests++;   // receiver backs off while words keep coming
         if (p == 2) drain();           // sender waits for every response
         random_traffic(RANDOM_TARGET / 2);
      end

      drain();
      repeat (END_WAIT) @(posedge clock);
      $display("Run covered %0d request words: %0d commands completed, %0d rejected,",
               words_counted, sb.done_count, sb.reject_count);
      $display("%0d register writes, %0d mismatches", csr_writes, sb.errors);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
